// ===== hw/rtl/pra_pkg.sv =====
// Shared types and constants for the physical region allocator.
// Used by every module of the block but pra_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pra_pkg;

  localparam int NODES      = 512;
  localparam int ADDR_BITS  = 52;
  localparam int CNT_W      = 41;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  localparam int SLOT_W = $clog2(NODES);
  localparam int LINK_W = $clog2(NODES + 1);
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);

  localparam int SPAN_W = ADDR_BITS + 2;
  localparam int CALC_W = ADDR_BITS + 3;

  localparam int MAP_CHUNK = 16;
  localparam int CHUNK_W   = $clog2(MAP_CHUNK);

  localparam logic [3:0] MT_BOOT_CODE    = 4'd3;
  localparam logic [3:0] MT_BOOT_DATA    = 4'd4;
  localparam logic [3:0] MT_CONVENTIONAL = 4'd7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_FREE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREE_MISS  = 2'd2,
    ST_LOAD_DROP  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                  opcode;
    logic [3:0]           entry_type;
    logic [ADDR_BITS-1:0] address;
    logic [CNT_W-1:0]     page_count;
    logic [31:0]          alignment;
    logic [ADDR_BITS:0]   limit_address;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] result_address;
    logic [CNT_W-1:0]     pages_free;
    logic [CNT_W-1:0]     pages_used;
    logic [CNT_W-1:0]     pages_total;
  } rsp_t;

  typedef struct packed {
    logic [SPAN_W-1:0] start;
    logic [SPAN_W-1:0] size;
    logic              used;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic              clear;
    logic              start;
    logic              set;
    logic [SLOT_W-1:0] set_idx;
    logic              rel;
    logic [SLOT_W-1:0] rel_idx;
  } slot_ctl_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] idx;
  } slot_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pra_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone and uses no package.
`timescale 1ns / 1ps
`default_nettype none

module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pra_slot_map.sv =====
// Occupancy map of the node store and the lowest-free-node search.
// Depends on pra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pra_slot_map import pra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  slot_ctl_t ctl,
  output slot_rsp_t rsp
);

  localparam int NCHUNK   = (NODES + MAP_CHUNK - 1) / MAP_CHUNK;
  localparam int CH_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int MAP_BITS = NCHUNK * MAP_CHUNK;
  localparam int MAP_W    = CH_W + CHUNK_W;

  logic [NODES-1:0]     busy;
  logic [MAP_BITS-1:0]  view;
  logic [CH_W-1:0]      ch;
  logic                 scanning;
  logic [MAP_CHUNK-1:0] word;
  logic [CHUNK_W-1:0]   pos;
  logic                 hit;
  logic                 last;
  logic [MAP_W-1:0]     found_idx;

  always_comb begin
    view = '1;
    view[NODES-1:0] = busy;
    word = view[{ch, CHUNK_W'(0)} +: MAP_CHUNK];
    pos = '0;
    for (int i = MAP_CHUNK - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = CHUNK_W'(i);
      end
    end
    hit = ~&word;
    last = (ch == CH_W'(NCHUNK - 1));
    found_idx = {ch, pos};
    rsp.done = scanning && (hit || last);
    rsp.found = scanning && hit;
    rsp.idx = found_idx[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      busy <= '0;
      scanning <= 1'b0;
      ch <= '0;
    end else begin
      if (ctl.set) begin
        busy[ctl.set_idx] <= 1'b1;
      end
      if (ctl.rel) begin
        busy[ctl.rel_idx] <= 1'b0;
      end
      if (ctl.start) begin
        scanning <= 1'b1;
        ch <= '0;
      end else if (scanning) begin
        if (hit || last) begin
          scanning <= 1'b0;
        end else begin
          ch <= ch + CH_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/physical_region_allocator.sv =====
// Top level of the physical region allocator: sequencer, node memories and counters.
// Depends on pra_pkg, pra_ram and pra_slot_map.
`timescale 1ns / 1ps
`default_nettype none

// The allocator works on one transaction at a time. Node records and links
// sit in two synchronous memories, and every list step is a read and a
// decision, with any change written back. Load runs a free node search.
// Allocate walks the list node by node and, on a hit, runs up to two free
// node searches; when the store is full, each misaligned candidate also
// costs one search. Free walks the list node by node.
// A new transaction is taken while the previous result waits on the output.
// The node memory needs no clearing pass after reset: only nodes marked in
// use in the occupancy map are ever used.
module physical_region_allocator import pra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_FIND,
    S_LD_TAIL,
    S_AL_DATA,
    S_AL_EVAL,
    S_AL_POST,
    S_AL_SPLIT,
    S_AL_FA,
    S_AL_FA2,
    S_AL_FA3,
    S_AL_FT,
    S_AL_FT_B,
    S_FR_DATA,
    S_FR_HIT,
    S_FR_NX,
    S_FR_PREV,
    S_DONE
  } state_t;

  state_t               state;
  logic [SLOT_W-1:0]    r;
  logic [SLOT_W-1:0]    a_q;
  logic [SLOT_W-1:0]    t_q;
  logic [SLOT_W-1:0]    p_q;
  logic [LINK_W-1:0]    head;
  logic [LINK_W-1:0]    tail;
  logic [LINK_W-1:0]    link_r;
  logic [LINK_W-1:0]    prev;
  logic [SPAN_W-1:0]    st_r;
  logic [SPAN_W-1:0]    size_r;
  logic [SPAN_W-1:0]    pre_q;
  logic [SPAN_W-1:0]    post_q;
  logic [SPAN_W-1:0]    pst;
  logic [SPAN_W-1:0]    psize;
  logic [SPAN_W-1:0]    req_q;
  logic [CALC_W-1:0]    al_q;
  logic [CALC_W-1:0]    end_q;
  logic [CALC_W-1:0]    alreq_q;
  logic                 used_r;
  logic                 pused;
  logic                 pre0;
  logic                 stopped;
  logic [ADDR_BITS-1:0] addr_q;
  logic [CNT_W-1:0]     pc_q;
  logic [CNT_W-1:0]     cnt_free;
  logic [CNT_W-1:0]     cnt_used;
  logic [CNT_W-1:0]     cnt_total;
  logic [31:0]          mask_q;
  logic [ADDR_BITS:0]   limit_q;
  status_t              status_q;
  logic [ADDR_BITS-1:0] res_q;

  logic              accept;
  logic              type_free;
  logic [SLOT_W-1:0] rd_addr;
  logic              a_we;
  logic [SLOT_W-1:0] a_waddr;
  node_t             a_wdata;
  node_t             a_rdata;
  logic              b_we;
  logic [SLOT_W-1:0] b_waddr;
  logic [LINK_W-1:0] b_wdata;
  logic [LINK_W-1:0] b_rdata;
  slot_ctl_t         slot_ctl;
  slot_rsp_t         slot_rsp;
  logic [CALC_W-1:0] alreq;
  logic              fit;
  logic              prev_ok;
  logic              next_join;
  logic              hit_free;
  logic              page0_single;
  node_t             load_node;

  pra_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  pra_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (rd_addr),
    .rdata (b_rdata)
  );

  pra_slot_map u_slot_map (
    .clk (clk),
    .rst (rst),
    .ctl (slot_ctl),
    .rsp (slot_rsp)
  );

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && !req_stall;

  always_comb begin
    type_free = req.entry_type inside {MT_BOOT_CODE, MT_BOOT_DATA, MT_CONVENTIONAL};
    alreq = al_q + CALC_W'(req_q);
    fit = !used_r && (alreq <= end_q) &&
          ((limit_q == '0) || (alreq <= CALC_W'(limit_q)));
    prev_ok = (prev != NIL_LINK) && !pused &&
              ((CALC_W'(pst) + CALC_W'(psize)) == CALC_W'(st_r));
    next_join = !a_rdata.used && (end_q == CALC_W'(a_rdata.start));
    hit_free = a_rdata.used && (a_rdata.start == SPAN_W'(addr_q));
    page0_single = (addr_q == '0) && (pc_q == CNT_W'(1));
    load_node.used = 1'b0;
    if (addr_q == '0) begin
      load_node.start = SPAN_W'(PAGE_BYTES);
      load_node.size = req_q - SPAN_W'(PAGE_BYTES);
    end else begin
      load_node.start = SPAN_W'(addr_q);
      load_node.size = req_q;
    end

    rd_addr = r;
    a_we = 1'b0;
    a_waddr = r;
    a_wdata = '{start: st_r, size: size_r, used: 1'b0};
    b_we = 1'b0;
    b_waddr = r;
    b_wdata = link_r;
    slot_ctl = '0;

    case (state)
      S_IDLE: begin
        rd_addr = head[SLOT_W-1:0];
        slot_ctl.clear = accept && (req.opcode == OP_CLEAR);
        slot_ctl.start = accept && (req.opcode == OP_LOAD) && !stopped && type_free &&
                         (req.page_count != '0);
      end
      S_LD_FIND: begin
        if (slot_rsp.found && !page0_single) begin
          slot_ctl.set = 1'b1;
          slot_ctl.set_idx = slot_rsp.idx;
          a_we = 1'b1;
          a_waddr = slot_rsp.idx;
          a_wdata = load_node;
          b_we = 1'b1;
          b_waddr = slot_rsp.idx;
          b_wdata = NIL_LINK;
        end
      end
      S_LD_TAIL: begin
        if (tail != NIL_LINK) begin
          b_we = 1'b1;
          b_waddr = tail[SLOT_W-1:0];
          b_wdata = LINK_W'(r);
        end
      end
      S_AL_EVAL: begin
        rd_addr = link_r[SLOT_W-1:0];
      end
      S_AL_SPLIT: begin
        if (pre0 && (post_q == '0)) begin
          a_we = 1'b1;
          a_wdata = '{start: st_r, size: size_r, used: 1'b1};
        end else begin
          slot_ctl.start = 1'b1;
        end
      end
      S_AL_FA: begin
        rd_addr = link_r[SLOT_W-1:0];
        if (slot_rsp.found) begin
          slot_ctl.set = 1'b1;
          slot_ctl.set_idx = slot_rsp.idx;
          a_we = 1'b1;
          a_waddr = slot_rsp.idx;
          a_wdata = '{start: al_q[SPAN_W-1:0], size: req_q, used: 1'b1};
        end
      end
      S_AL_FA2: begin
        b_we = 1'b1;
        b_waddr = a_q;
        b_wdata = link_r;
        a_we = 1'b1;
        a_wdata = '{start: st_r, size: pre_q, used: 1'b0};
      end
      S_AL_FA3: begin
        b_we = 1'b1;
        b_wdata = LINK_W'(a_q);
        slot_ctl.start = (post_q != '0);
      end
      S_AL_FT: begin
        if (slot_rsp.found) begin
          slot_ctl.set = 1'b1;
          slot_ctl.set_idx = slot_rsp.idx;
          a_we = 1'b1;
          a_waddr = slot_rsp.idx;
          a_wdata = '{start: alreq_q[SPAN_W-1:0], size: post_q, used: 1'b0};
          b_we = 1'b1;
          b_waddr = slot_rsp.idx;
          b_wdata = link_r;
        end else if (slot_rsp.done && pre0) begin
          a_we = 1'b1;
          a_wdata = '{start: st_r, size: size_r, used: 1'b1};
        end
      end
      S_AL_FT_B: begin
        b_we = 1'b1;
        b_waddr = p_q;
        b_wdata = LINK_W'(t_q);
        if (pre0) begin
          a_we = 1'b1;
          a_wdata = '{start: st_r, size: req_q, used: 1'b1};
        end
      end
      S_FR_DATA: begin
        rd_addr = b_rdata[SLOT_W-1:0];
      end
      S_FR_HIT: begin
        rd_addr = link_r[SLOT_W-1:0];
      end
      S_FR_NX: begin
        if (next_join) begin
          slot_ctl.rel = 1'b1;
          slot_ctl.rel_idx = link_r[SLOT_W-1:0];
        end
      end
      S_FR_PREV: begin
        a_we = 1'b1;
        b_we = 1'b1;
        if (prev_ok) begin
          a_waddr = prev[SLOT_W-1:0];
          a_wdata = '{start: pst, size: psize + size_r, used: 1'b0};
          b_waddr = prev[SLOT_W-1:0];
          slot_ctl.rel = 1'b1;
          slot_ctl.rel_idx = r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= NIL_LINK;
      tail <= NIL_LINK;
      stopped <= 1'b0;
      cnt_free <= '0;
      cnt_used <= '0;
      cnt_total <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr_q <= req.address;
            pc_q <= req.page_count;
            mask_q <= (req.alignment == '0) ? '0 : req.alignment - 32'd1;
            limit_q <= req.limit_address;
            req_q <= SPAN_W'(req.page_count) << PAGE_SHIFT;
            status_q <= ST_OK;
            res_q <= '0;
            state <= S_DONE;
            case (req.opcode)
              OP_CLEAR: begin
                head <= NIL_LINK;
                tail <= NIL_LINK;
                stopped <= 1'b0;
                cnt_free <= '0;
                cnt_used <= '0;
                cnt_total <= '0;
              end
              OP_LOAD: begin
                if (stopped) begin
                  status_q <= ST_LOAD_DROP;
                end else begin
                  cnt_total <= cnt_total + req.page_count;
                  if (type_free && (req.page_count != '0)) begin
                    state <= S_LD_FIND;
                  end
                end
              end
              OP_ALLOC: begin
                if ((req.page_count == '0) || (head == NIL_LINK)) begin
                  status_q <= ST_ALLOC_FAIL;
                end else begin
                  r <= head[SLOT_W-1:0];
                  state <= S_AL_DATA;
                end
              end
              OP_FREE: begin
                if ((req.address == '0) || (req.page_count == '0) || (head == NIL_LINK)) begin
                  status_q <= ST_FREE_MISS;
                end else begin
                  r <= head[SLOT_W-1:0];
                  prev <= NIL_LINK;
                  state <= S_FR_DATA;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LD_FIND: begin
          if (slot_rsp.done) begin
            if (!slot_rsp.found) begin
              stopped <= 1'b1;
              status_q <= ST_LOAD_DROP;
              state <= S_DONE;
            end else if (page0_single) begin
              state <= S_DONE;
            end else begin
              r <= slot_rsp.idx;
              state <= S_LD_TAIL;
            end
          end
        end
        S_LD_TAIL: begin
          if (tail == NIL_LINK) begin
            head <= LINK_W'(r);
          end
          tail <= LINK_W'(r);
          cnt_free <= cnt_free + pc_q;
          state <= S_DONE;
        end
        S_AL_DATA: begin
          st_r <= a_rdata.start;
          size_r <= a_rdata.size;
          used_r <= a_rdata.used;
          link_r <= b_rdata;
          al_q <= (CALC_W'(a_rdata.start) + CALC_W'(mask_q)) & ~CALC_W'(mask_q);
          end_q <= CALC_W'(a_rdata.start) + CALC_W'(a_rdata.size);
          state <= S_AL_EVAL;
        end
        S_AL_EVAL: begin
          if (fit) begin
            alreq_q <= alreq;
            state <= S_AL_POST;
          end else if (link_r == NIL_LINK) begin
            status_q <= ST_ALLOC_FAIL;
            state <= S_DONE;
          end else begin
            r <= link_r[SLOT_W-1:0];
            state <= S_AL_DATA;
          end
        end
        S_AL_POST: begin
          post_q <= SPAN_W'(end_q - alreq_q);
          pre_q <= SPAN_W'(al_q - CALC_W'(st_r));
          pre0 <= (al_q == CALC_W'(st_r));
          state <= S_AL_SPLIT;
        end
        S_AL_SPLIT: begin
          if (pre0) begin
            if (post_q != '0) begin
              p_q <= r;
              state <= S_AL_FT;
            end else begin
              cnt_used <= cnt_used + pc_q;
              cnt_free <= cnt_free - pc_q;
              res_q <= al_q[ADDR_BITS-1:0];
              state <= S_DONE;
            end
          end else begin
            state <= S_AL_FA;
          end
        end
        S_AL_FA: begin
          if (slot_rsp.done) begin
            if (slot_rsp.found) begin
              a_q <= slot_rsp.idx;
              state <= S_AL_FA2;
            end else if (link_r == NIL_LINK) begin
              status_q <= ST_ALLOC_FAIL;
              state <= S_DONE;
            end else begin
              r <= link_r[SLOT_W-1:0];
              state <= S_AL_DATA;
            end
          end
        end
        S_AL_FA2: begin
          state <= S_AL_FA3;
        end
        S_AL_FA3: begin
          if (tail == LINK_W'(r)) begin
            tail <= LINK_W'(a_q);
          end
          if (post_q != '0) begin
            p_q <= a_q;
            state <= S_AL_FT;
          end else begin
            cnt_used <= cnt_used + pc_q;
            cnt_free <= cnt_free - pc_q;
            res_q <= al_q[ADDR_BITS-1:0];
            state <= S_DONE;
          end
        end
        S_AL_FT: begin
          if (slot_rsp.done) begin
            if (slot_rsp.found) begin
              t_q <= slot_rsp.idx;
              state <= S_AL_FT_B;
            end else begin
              cnt_used <= cnt_used + pc_q;
              cnt_free <= cnt_free - pc_q;
              res_q <= al_q[ADDR_BITS-1:0];
              state <= S_DONE;
            end
          end
        end
        S_AL_FT_B: begin
          if (tail == LINK_W'(p_q)) begin
            tail <= LINK_W'(t_q);
          end
          cnt_used <= cnt_used + pc_q;
          cnt_free <= cnt_free - pc_q;
          res_q <= al_q[ADDR_BITS-1:0];
          state <= S_DONE;
        end
        S_FR_DATA: begin
          if (hit_free) begin
            st_r <= a_rdata.start;
            size_r <= a_rdata.size;
            link_r <= b_rdata;
            state <= S_FR_HIT;
          end else begin
            prev <= LINK_W'(r);
            pst <= a_rdata.start;
            psize <= a_rdata.size;
            pused <= a_rdata.used;
            if (b_rdata == NIL_LINK) begin
              status_q <= ST_FREE_MISS;
              state <= S_DONE;
            end else begin
              r <= b_rdata[SLOT_W-1:0];
            end
          end
        end
        S_FR_HIT: begin
          cnt_used <= cnt_used - pc_q;
          cnt_free <= cnt_free + pc_q;
          end_q <= CALC_W'(st_r) + CALC_W'(size_r);
          state <= (link_r != NIL_LINK) ? S_FR_NX : S_FR_PREV;
        end
        S_FR_NX: begin
          if (next_join) begin
            size_r <= size_r + a_rdata.size;
            link_r <= b_rdata;
            if (tail == link_r) begin
              tail <= LINK_W'(r);
            end
          end
          state <= S_FR_PREV;
        end
        S_FR_PREV: begin
          if (prev_ok && (tail == LINK_W'(r))) begin
            tail <= prev;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp <= '{status: status_q, result_address: res_q, pages_free: cnt_free,
                     pages_used: cnt_used, pages_total: cnt_total};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pra_checker.sv =====
// Port-level checks for the physical region allocator, bound to the top level.
// Depends on pra_pkg and physical_region_allocator.
`timescale 1ns / 1ps
`default_nettype none

module pra_checker import pra_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled response changed or vanished.");

  a_rsp_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> $past(!rsp_stall))
    else $error("Response dropped without a transaction.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Request accepted while the previous one is still in work.");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.result_address == '0))
    else $error("Failed transaction reports an address.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("Response valid right after reset.");

endmodule

bind physical_region_allocator pra_checker u_pra_checker (.*);

`default_nettype wire

// ===== dv/tb_physical_region_allocator.sv =====
// Self-checking testbench for physical_region_allocator: a directed table, then random
// load/allocate/free traffic checked against a behavioral region-list model.
// Depends on pra_pkg and the physical_region_allocator RTL.
`timescale 1ns / 1ps

module tb_physical_region_allocator;
  import pra_pkg::*;

  typedef bit [63:0] u64;
  typedef struct {
    u64       addr;
    bit [40:0] pages;
  } grant_t;
  typedef struct {
    req_t q;
    bit   has_exp;
    rsp_t e;
  } row_t;

  localparam int WATCHDOG = 40000;
  localparam u64 AMASK = (u64'(1) << 52) - 1;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;

  physical_region_allocator dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Behavioral copy of the region list.
  u64        rg_start[NODES];
  u64        rg_size[NODES];
  bit        rg_used[NODES];
  int        rg_link[NODES];
  int        rg_head, rg_tail;
  bit        rg_stopped;
  bit [40:0] pg_free, pg_used, pg_total;

  rsp_t   pending_rsp[$];
  grant_t live_grants[$];
  int     send_idle, recv_idle, hold_left;
  int     mismatches, idle_cycles;
  int     n_items, n_loads, n_allocs, n_grants, n_frees;

  function automatic int empty_slot();
    for (int i = 0; i < NODES; i++)
      if (rg_size[i] == 0) return i;
    return NODES;
  endfunction

  function automatic void drop_slot(int n);
    rg_start[n] = 0;
    rg_size[n] = 0;
    rg_used[n] = 0;
    rg_link[n] = NODES;
  endfunction

  function automatic int succ(int n);
    return rg_link[n] < NODES ? rg_link[n] : NODES;
  endfunction

  function automatic void splice(int after, int n);
    rg_link[n] = rg_link[after];
    rg_link[after] = n;
    if (rg_tail == after) rg_tail = n;
  endfunction

  function automatic void merge(int a, int b);
    rg_size[a] += rg_size[b];
    rg_link[a] = rg_link[b];
    if (rg_tail == b) rg_tail = a;
    drop_slot(b);
  endfunction

  function automatic void wipe();
    for (int i = 0; i < NODES; i++) drop_slot(i);
    rg_head = NODES;
    rg_tail = NODES;
    rg_stopped = 0;
    pg_free = 0;
    pg_used = 0;
    pg_total = 0;
  endfunction

  function automatic status_t load_region(logic [3:0] kind, u64 addr, bit [40:0] pc);
    int n;
    if (rg_stopped) return ST_LOAD_DROP;
    pg_total += pc;
    if (!(kind == MT_CONVENTIONAL || kind == MT_BOOT_CODE || kind == MT_BOOT_DATA) || pc == 0)
      return ST_OK;
    n = empty_slot();
    if (n == NODES) begin
      rg_stopped = 1;
      return ST_LOAD_DROP;
    end
    rg_start[n] = addr;
    rg_size[n] = u64'(pc) << PAGE_SHIFT;
    rg_used[n] = 0;
    rg_link[n] = NODES;
    if (addr == 0) begin
      if (rg_size[n] <= PAGE_BYTES) begin
        drop_slot(n);
        return ST_OK;
      end
      rg_start[n] = PAGE_BYTES;
      rg_size[n] -= PAGE_BYTES;
    end
    if (rg_tail >= NODES) rg_head = n;
    else rg_link[rg_tail] = n;
    rg_tail = n;
    pg_free += pc;
    return ST_OK;
  endfunction

  function automatic status_t carve(bit [40:0] pc, u64 align, u64 lim, output u64 res);
    u64 want, m, st, fin, al, pre, post;
    int r, steps, t, a;
    want = u64'(pc) << PAGE_SHIFT;
    m = (align == 0 ? 1 : align) - 1;
    r = rg_head < NODES ? rg_head : NODES;
    steps = 0;
    res = 0;
    if (pc == 0) return ST_ALLOC_FAIL;
    while (r != NODES && steps < NODES) begin
      st = rg_start[r];
      fin = st + rg_size[r];
      al = (st + m) & ~m;
      steps++;
      if (rg_used[r] || al + want > fin || (lim != 0 && al + want > lim)) begin
        r = succ(r);
        continue;
      end
      pre = al - st;
      post = fin - (al + want);
      if (pre == 0) begin
        if (post > 0) begin
          t = empty_slot();
          if (t != NODES) begin
            rg_start[t] = al + want;
            rg_size[t] = post;
            rg_used[t] = 0;
            splice(r, t);
            rg_size[r] = want;
          end
        end
        rg_used[r] = 1;
      end else begin
        a = empty_slot();
        if (a == NODES) begin
          r = succ(r);
          continue;
        end
        rg_start[a] = al;
        rg_size[a] = want;
        rg_used[a] = 1;
        splice(r, a);
        rg_size[r] = pre;
        if (post > 0) begin
          t = empty_slot();
          if (t != NODES) begin
            rg_start[t] = al + want;
            rg_size[t] = post;
            rg_used[t] = 0;
            splice(a, t);
          end
        end
      end
      pg_used += pc;
      pg_free -= pc;
      res = al;
      return ST_OK;
    end
    return ST_ALLOC_FAIL;
  endfunction

  function automatic status_t give_back(u64 addr, bit [40:0] pc);
    int prev, r, steps, nx;
    prev = NODES;
    r = rg_head < NODES ? rg_head : NODES;
    steps = 0;
    if (addr == 0 || pc == 0) return ST_FREE_MISS;
    while (r != NODES && steps < NODES) begin
      steps++;
      if (rg_start[r] == addr && rg_used[r]) begin
        nx = succ(r);
        rg_used[r] = 0;
        pg_used -= pc;
        pg_free += pc;
        if (nx != NODES && !rg_used[nx] && rg_start[r] + rg_size[r] == rg_start[nx])
          merge(r, nx);
        if (prev != NODES && !rg_used[prev] && rg_start[prev] + rg_size[prev] == rg_start[r])
          merge(prev, r);
        return ST_OK;
      end
      prev = r;
      r = succ(r);
    end
    return ST_FREE_MISS;
  endfunction

  function automatic rsp_t predict_region_op(req_t q);
    rsp_t o;
    u64 res;
    o = '0;
    res = 0;
    case (q.opcode)
      OP_CLEAR: wipe();
      OP_LOAD: begin
        o.status = load_region(q.entry_type, u64'(q.address), q.page_count);
        n_loads++;
      end
      OP_ALLOC: begin
        o.status = carve(q.page_count, u64'(q.alignment), u64'(q.limit_address), res);
        n_allocs++;
        if (o.status == ST_OK) begin
          n_grants++;
          live_grants.push_back('{res & AMASK, q.page_count});
        end
      end
      default: begin
        o.status = give_back(u64'(q.address), q.page_count);
        n_frees++;
      end
    endcase
    if (q.opcode == OP_CLEAR) live_grants.delete();
    o.result_address = res[ADDR_BITS-1:0];
    o.pages_free = pg_free;
    o.pages_used = pg_used;
    o.pages_total = pg_total;
    return o;
  endfunction

  task automatic issue(req_t q, bit has_exp = 0, rsp_t e = '0);
    rsp_t p;
    req <= q;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_items++;
    p = predict_region_op(q);
    pending_rsp.push_back(has_exp ? e : p);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 0;
    wait (pending_rsp.size() == 0);
    @(posedge clk);
  endtask

  function automatic req_t make_item(bit fill_mode);
    req_t q;
    int pick, g;
    q = '0;
    q.alignment = 1;
    pick = $urandom_range(99);
    if (pick < 5) begin
      q = {$urandom, $urandom, $urandom, $urandom};
    end else if (pick < 7 && !fill_mode) begin
      q.opcode = OP_CLEAR;
    end else if (pick < 27) begin
      q.opcode = OP_LOAD;
      case ($urandom_range(3))
        0: q.entry_type = MT_BOOT_CODE;
        1: q.entry_type = MT_BOOT_DATA;
        2: q.entry_type = 4'($urandom_range(15));
        default: q.entry_type = MT_CONVENTIONAL;
      endcase
      q.address = ADDR_BITS'($urandom_range(0, 4095)) << PAGE_SHIFT;
      q.page_count = $urandom_range(0, 64);
    end else if (pick < 62) begin
      q.opcode = OP_ALLOC;
      q.page_count = ($urandom_range(9) == 0) ? 41'($urandom_range(0, 512)) :
                     41'($urandom_range(1, 8));
      case ($urandom_range(5))
        0: q.alignment = 0;
        1: q.alignment = $urandom_range(1, 100000);
        default: q.alignment = 32'd1 << $urandom_range(0, 20);
      endcase
      if ($urandom_range(3) == 0)
        q.limit_address = 53'($urandom_range(1, 20000)) << PAGE_SHIFT;
    end else begin
      q.opcode = OP_FREE;
      if (live_grants.size() > 0 && $urandom_range(9) != 0) begin
        g = $urandom_range(live_grants.size() - 1);
        q.address = live_grants[g].addr[ADDR_BITS-1:0];
        q.page_count = live_grants[g].pages;
        live_grants.delete(g);
      end else begin
        q.address = ADDR_BITS'($urandom_range(0, 8191)) << PAGE_SHIFT;
        q.page_count = $urandom_range(0, 4);
      end
    end
    return q;
  endfunction

  // Response checker and receiver stall generation.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %p", rsp);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status || rsp.result_address !== e.result_address ||
            rsp.pages_free !== e.pages_free || rsp.pages_used !== e.pages_used ||
            rsp.pages_total !== e.pages_total) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, rsp);
        end
      end
    end
    if (hold_left > 0) begin
      rsp_stall <= 1;
      hold_left--;
    end else begin
      rsp_stall <= recv_idle > 0 && $urandom_range(99) < recv_idle;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(op_t op, logic [3:0] kind, u64 addr, u64 pc, u64 al, u64 lim,
                              bit has_exp = 0, status_t st = ST_OK, u64 fr = 0, u64 tot = 0);
    row_t r;
    r.q = '{op, kind, addr[ADDR_BITS-1:0], pc[CNT_W-1:0], al[31:0], lim[ADDR_BITS:0]};
    r.has_exp = has_exp;
    r.e = '0;
    r.e.status = st;
    r.e.pages_free = fr;
    r.e.pages_total = tot;
    return r;
  endfunction

  initial begin
    req_t q;
    wipe();
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    mismatches = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back(mk(OP_ALLOC, 0, 0, 1, 1, 0, 1, ST_ALLOC_FAIL));
    rows.push_back(mk(OP_FREE, 0, 'h1000, 1, 1, 0, 1, ST_FREE_MISS));
    rows.push_back(mk(OP_LOAD, MT_CONVENTIONAL, 0, 1, 1, 0, 1, ST_OK, 0, 1));
    rows.push_back(mk(OP_LOAD, 4'd2, 'h100000, 10, 1, 0, 1, ST_OK, 0, 11));
    rows.push_back(mk(OP_LOAD, MT_CONVENTIONAL, 0, 16, 1, 0, 1, ST_OK, 16, 27));
    rows.push_back(mk(OP_LOAD, MT_BOOT_CODE, 'h100000, 0, 1, 0, 1, ST_OK, 16, 27));
    rows.push_back(mk(OP_LOAD, MT_BOOT_DATA, 'h200000, 256, 1, 0));
    rows.push_back(mk(OP_LOAD, MT_BOOT_CODE, 'hF_FFFF_FFFF_F000, 1, 1, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 1, 1, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 2, 'h10000, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 0, 1, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 4, 0, 'h6000));
    rows.push_back(mk(OP_ALLOC, 0, 0, 'h100_0000_0000, 1, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 1, 'h8000_0000, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 3, 3, 0));
    rows.push_back(mk(OP_ALLOC, 0, 0, 1, 1, 'h10_0000_0000_0000));
    rows.push_back(mk(OP_FREE, 0, 'h2000, 1, 1, 0));
    rows.push_back(mk(OP_FREE, 0, 'h2000, 1, 1, 0));
    rows.push_back(mk(OP_FREE, 0, 'h10000, 0, 1, 0));
    rows.push_back(mk(OP_FREE, 0, 0, 1, 1, 0));
    rows.push_back(mk(OP_FREE, 0, 'hF_FFFF_FFFF_FFFF, 'h1FF_FFFF_FFFF, 1, 0));
    rows.push_back(mk(OP_LOAD, 4'hF, 'hF_FFFF_FFFF_FFFF, 'h1FF_FFFF_FFFF, 'hFFFF_FFFF,
                      'h1F_FFFF_FFFF_FFFF));
    rows.push_back(mk(OP_CLEAR, 0, 0, 0, 1, 0, 1, ST_OK, 0, 0));
    foreach (rows[i]) issue(rows[i].q, rows[i].has_exp, rows[i].e);
    drain();

    // Sender mostly busy, receiver mostly stalled; a long receiver hold-off first.
    send_idle = 27;
    recv_idle = 80;
    hold_left = 400;
    for (int i = 0; i < 180; i++) begin
      issue(make_item(0));
      if (i == 90) drain();
    end
    drain();

    send_idle = 80;
    recv_idle = 27;
    for (int i = 0; i < 180; i++) issue(make_item(0));

    // Fill the node store so that the full-store paths are taken.
    send_idle = 0;
    recv_idle = 0;
    q = '0;
    issue(q);
    for (int i = 0; i < NODES + 2; i++) begin
      q = '0;
      q.opcode = OP_LOAD;
      q.entry_type = MT_CONVENTIONAL;
      q.address = ADDR_BITS'(4 * i + 1) << PAGE_SHIFT;
      q.page_count = 2;
      q.alignment = 1;
      issue(q);
    end
    q.opcode = OP_ALLOC;
    q.page_count = 1;
    q.alignment = 'h2000;
    issue(q);
    q.alignment = 1;
    issue(q);
    for (int i = 0; i < 30; i++) issue(make_item(1));

    for (int i = 0; i < 180; i++) issue(make_item(0));
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d transactions: %0d loads, %0d allocations (%0d granted), %0d frees.",
             n_items, n_loads, n_allocs, n_grants, n_frees);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
